### hw/rtl/hvac_link_frame_status_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the link frame status decoder
// Shared concurrent-check forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef HVAC_LINK_FRAME_STATUS_DECODER_CORE_MACROS_SVH
`define HVAC_LINK_FRAME_STATUS_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define HLFSD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hlfsd check failed");

// next-cycle implication
`define HLFSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hlfsd check failed");

`endif

### hw/rtl/hlfsd_pkg.sv
// ----------------------------------------------------------------------------
// hlfsd_pkg
// Types and constants shared by the link frame status decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hlfsd_pkg;

  localparam int FRAME_BYTES = 20;
  localparam int IDX_W       = 5;
  localparam int EVT_SLOTS   = 8;
  localparam int CFG_W       = 16;

  // input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC_WINDOW  = 2'd0;
  localparam logic [1:0] CFG_LOSS_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_TROOM_HOLD   = 2'd2;
  localparam logic [1:0] CFG_TROOM_DELTA  = 2'd3;

  // fixed event slots, in emission order
  localparam int SLOT_SYNC   = 0;
  localparam int SLOT_POWER  = 1; // also carries the bad frame event
  localparam int SLOT_MODE   = 2;
  localparam int SLOT_FAN    = 3;
  localparam int SLOT_VANES  = 4;
  localparam int SLOT_TROOM  = 5;
  localparam int SLOT_SETPT  = 6;
  localparam int SLOT_ERROR  = 7;

  typedef enum logic [3:0] {
    EV_BAD   = 4'd0,
    EV_SYNC  = 4'd1,
    EV_POWER = 4'd2,
    EV_MODE  = 4'd3,
    EV_FAN   = 4'd4,
    EV_VANES = 4'd5,
    EV_TROOM = 4'd6,
    EV_SETPT = 4'd7,
    EV_ERROR = 4'd8
  } hlfsd_event_e;

  typedef struct packed {
    hlfsd_event_e code;
    logic [7:0]   value;
  } hlfsd_evt_t;

  // all events caused by one input item
  typedef struct packed {
    logic [EVT_SLOTS-1:0]       mask;
    hlfsd_evt_t [EVT_SLOTS-1:0] evts;
  } hlfsd_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hlfsd_qstat_t;

endpackage

`default_nettype wire

### hw/rtl/hlfsd_in_if.sv
// ----------------------------------------------------------------------------
// hlfsd_in_if
// Input channel: received link bytes and millisecond ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface hlfsd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, kind, rx_byte, frame_start, input ready);
  modport sink   (input valid, kind, rx_byte, frame_start, output ready);
endinterface

`default_nettype wire

### hw/rtl/hlfsd_out_if.sv
// ----------------------------------------------------------------------------
// hlfsd_out_if
// Output channel: decoded status events.
// ----------------------------------------------------------------------------
`default_nettype none

interface hlfsd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;
  logic [7:0] event_value;
  logic       last_of_run;

  modport source (output valid, event_code, event_value, last_of_run, input ready);
  modport sink   (input valid, event_code, event_value, last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/hlfsd_front.sv
// ----------------------------------------------------------------------------
// hlfsd_front
// Accepts bytes and ticks, keeps the frame store, timers and last reported
// values, and builds the event bundle for each item in the cycle it arrives.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hvac_link_frame_status_decoder_core_macros.svh"

module hlfsd_front
  import hlfsd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  hlfsd_in_if.sink               in_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire hlfsd_qstat_t      qstat_i,
  output logic                   push_o,
  output hlfsd_bundle_t          bundle_o
);

  logic [9:0]  win_q;
  logic [13:0] loss_q;
  logic [15:0] hold_q;
  logic [7:0]  delta_q;

  logic [IDX_W-1:0] byte_idx_q, byte_idx_d;
  logic [7:0]       store_q [FRAME_BYTES];
  logic [15:0]      sum_q, sum_d;
  logic             diff_q, diff_d;
  logic             synced_q, synced_d;
  logic [15:0]      msp_q, msp_d;
  logic [15:0]      mst_q, mst_d;
  logic [1:0]       last_power_q, last_power_d;
  logic [7:0]       last_mode_q, last_mode_d;
  logic [2:0]       last_fan_q, last_fan_d;
  logic [7:0]       last_vanes_q, last_vanes_d;
  logic [7:0]       last_troom_q, last_troom_d;
  logic [6:0]       last_setpt_q, last_setpt_d;
  logic [8:0]       last_err_q, last_err_d;

  logic             fire;
  logic [IDX_W-1:0] idx;
  logic [7:0]       b, b0, b1, b2, b3, b4, b6;
  logic [15:0]      sum_base, sum_new, msp_inc, mst_inc;
  logic             diff_new, frame_ok, last_byte;
  logic [7:0]       mode_v, vanes_v, troom_d, troom_mag;
  logic [2:0]       fan_v;
  logic [6:0]       setpt_v;

  assign fire       = in_i.valid & in_i.ready;
  assign in_i.ready = ~qstat_i.full;

  assign b  = in_i.rx_byte;
  assign b0 = store_q[0];
  assign b1 = store_q[1];
  assign b2 = store_q[2];
  assign b3 = store_q[3];
  assign b4 = store_q[4];
  assign b6 = store_q[6];

  assign idx       = in_i.frame_start ? '0 : byte_idx_q;
  assign last_byte = (idx == IDX_W'(FRAME_BYTES - 1));
  assign sum_base  = (idx == '0) ? 16'd0 : sum_q;
  assign diff_new  = ((idx == '0) ? 1'b0 : diff_q) | (store_q[idx] != b);
  assign sum_new   = (idx < IDX_W'(FRAME_BYTES - 2)) ? sum_base + {8'd0, b} : sum_base;
  assign msp_inc   = (msp_q == 16'hffff) ? msp_q : msp_q + 16'd1;
  assign mst_inc   = (mst_q == 16'hffff) ? mst_q : mst_q + 16'd1;

  // byte 19 is the one arriving now; the checksum covers bytes 0 to 17
  assign frame_ok = ((b0 & 8'hfe) == 8'h6c) && (b1 == 8'h80) && (b2 == 8'h04) &&
                    ({store_q[FRAME_BYTES-2], b} == sum_base);

  assign mode_v    = b0 & 8'h1c;
  assign fan_v     = b6[6] ? 3'd4 : {1'b0, b1[1:0]} + 3'd1;
  assign vanes_v   = {b0[7:6], 2'b00, b1[7], 1'b0, b1[5:4]};
  assign troom_d   = b3 - last_troom_q;
  assign troom_mag = troom_d[7] ? 8'd0 - troom_d : troom_d;
  assign setpt_v   = {1'b0, b2[6:1]};

  always_comb begin
    byte_idx_d   = byte_idx_q;
    sum_d        = sum_q;
    diff_d       = diff_q;
    synced_d     = synced_q;
    msp_d        = msp_q;
    mst_d        = mst_q;
    last_power_d = last_power_q;
    last_mode_d  = last_mode_q;
    last_fan_d   = last_fan_q;
    last_vanes_d = last_vanes_q;
    last_troom_d = last_troom_q;
    last_setpt_d = last_setpt_q;
    last_err_d   = last_err_q;

    bundle_o.mask = '0;
    bundle_o.evts[SLOT_SYNC]  = '{code: EV_SYNC,  value: 8'd0};
    bundle_o.evts[SLOT_POWER] = '{code: EV_POWER, value: {7'd0, b0[0]}};
    bundle_o.evts[SLOT_MODE]  = '{code: EV_MODE,
                                  value: (mode_v <= 8'h10) ? (mode_v >> 2) : 8'd5};
    bundle_o.evts[SLOT_FAN]   = '{code: EV_FAN,   value: {5'd0, fan_v}};
    bundle_o.evts[SLOT_VANES] = '{code: EV_VANES, value: 8'd0};
    bundle_o.evts[SLOT_TROOM] = '{code: EV_TROOM, value: b3};
    bundle_o.evts[SLOT_SETPT] = '{code: EV_SETPT, value: {1'b0, setpt_v}};
    bundle_o.evts[SLOT_ERROR] = '{code: EV_ERROR, value: b4};

    if ((vanes_v & 8'h88) == 8'h00) begin
      bundle_o.evts[SLOT_VANES].value = 8'd0;
    end else if (vanes_v[6]) begin
      bundle_o.evts[SLOT_VANES].value = 8'd5;
    end else begin
      bundle_o.evts[SLOT_VANES].value = {6'd0, vanes_v[1:0]} + 8'd1;
    end

    if (fire && in_i.kind == KIND_TICK) begin
      msp_d = msp_inc;
      mst_d = mst_inc;
      if (msp_inc > {2'd0, loss_q} && synced_q) begin
        synced_d = 1'b0;
        bundle_o.mask[SLOT_SYNC] = 1'b1;
      end
    end else if (fire) begin
      sum_d      = sum_new;
      diff_d     = diff_new;
      byte_idx_d = last_byte ? '0 : idx + IDX_W'(1);
      if (last_byte) begin
        if (!frame_ok) begin
          if (synced_q) begin
            synced_d = 1'b0;
            bundle_o.mask[SLOT_SYNC] = 1'b1;
          end
          bundle_o.mask[SLOT_POWER] = 1'b1;
          bundle_o.evts[SLOT_POWER] = '{code: EV_BAD, value: 8'd0};
        end else begin
          msp_d = 16'd0;
          if (msp_q < {6'd0, win_q} && !synced_q) begin
            synced_d = 1'b1;
            bundle_o.mask[SLOT_SYNC]        = 1'b1;
            bundle_o.evts[SLOT_SYNC].value  = 8'd1;
          end
          if (diff_new) begin
            if ({1'b0, b0[0]} != last_power_q) begin
              last_power_d = {1'b0, b0[0]};
              bundle_o.mask[SLOT_POWER] = 1'b1;
            end
            if (mode_v != last_mode_q) begin
              last_mode_d = mode_v;
              bundle_o.mask[SLOT_MODE] = 1'b1;
            end
            if (fan_v != last_fan_q) begin
              last_fan_d = fan_v;
              bundle_o.mask[SLOT_FAN] = 1'b1;
            end
            if (vanes_v != last_vanes_q) begin
              last_vanes_d = vanes_v;
              bundle_o.mask[SLOT_VANES] = 1'b1;
            end
            if (troom_mag > delta_q && mst_q > hold_q) begin
              mst_d        = 16'd0;
              last_troom_d = b3;
              bundle_o.mask[SLOT_TROOM] = 1'b1;
            end
            if (setpt_v != last_setpt_q) begin
              last_setpt_d = setpt_v;
              bundle_o.mask[SLOT_SETPT] = 1'b1;
            end
            if ({1'b0, b4} != last_err_q) begin
              last_err_d = {1'b0, b4};
              bundle_o.mask[SLOT_ERROR] = 1'b1;
            end
          end
        end
      end
    end
  end

  assign push_o = |bundle_o.mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= 10'd60;
      loss_q  <= 14'd200;
      hold_q  <= 16'd30000;
      delta_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_WINDOW:  win_q   <= cfg_wdata_i[9:0];
        CFG_LOSS_TIMEOUT: loss_q  <= cfg_wdata_i[13:0];
        CFG_TROOM_HOLD:   hold_q  <= cfg_wdata_i[15:0];
        CFG_TROOM_DELTA:  delta_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_q[i] <= 8'd0;
      end
    end else if (fire && in_i.kind == KIND_BYTE) begin
      store_q[idx] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q   <= '0;
      sum_q        <= 16'd0;
      diff_q       <= 1'b0;
      synced_q     <= 1'b0;
      msp_q        <= 16'd0;
      mst_q        <= 16'd0;
      last_power_q <= 2'd2;
      last_mode_q  <= 8'hff;
      last_fan_q   <= 3'd0;
      last_vanes_q <= 8'hff;
      last_troom_q <= 8'd0;
      last_setpt_q <= 7'h7f;
      last_err_q   <= 9'h100;
    end else begin
      byte_idx_q   <= byte_idx_d;
      sum_q        <= sum_d;
      diff_q       <= diff_d;
      synced_q     <= synced_d;
      msp_q        <= msp_d;
      mst_q        <= mst_d;
      last_power_q <= last_power_d;
      last_mode_q  <= last_mode_d;
      last_fan_q   <= last_fan_d;
      last_vanes_q <= last_vanes_d;
      last_troom_q <= last_troom_d;
      last_setpt_q <= last_setpt_d;
      last_err_q   <= last_err_d;
    end
  end

  `HLFSD_ASSERT_NOW(a_idx_range, clk_i, rst_ni, 1'b1, byte_idx_q < IDX_W'(FRAME_BYTES))
  `HLFSD_ASSERT_NEXT(a_tick_keeps_idx, clk_i, rst_ni, fire && in_i.kind == KIND_TICK, byte_idx_q == $past(byte_idx_q))
  `HLFSD_ASSERT_NOW(a_push_room, clk_i, rst_ni, push_o, !qstat_i.full)

endmodule

`default_nettype wire

### hw/rtl/hlfsd_queue.sv
// ----------------------------------------------------------------------------
// hlfsd_queue
// Small FIFO of event bundles between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hvac_link_frame_status_decoder_core_macros.svh"

module hlfsd_queue
  import hlfsd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire hlfsd_bundle_t wdata_i,
  input  wire logic          pop_i,
  output hlfsd_bundle_t      rdata_o,
  output hlfsd_qstat_t       qstat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hlfsd_bundle_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign qstat_o = '{full: (cnt_q == CNT_W'(DEPTH)), empty: (cnt_q == '0)};
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  `HLFSD_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop_i, !qstat_o.empty)
  `HLFSD_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push_i, !qstat_o.full)
  `HLFSD_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + CNT_W'(1))

endmodule

`default_nettype wire

### hw/rtl/hlfsd_back.sv
// ----------------------------------------------------------------------------
// hlfsd_back
// Holds one event bundle and hands its events out one beat at a time,
// lowest slot first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hvac_link_frame_status_decoder_core_macros.svh"

module hlfsd_back
  import hlfsd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hlfsd_qstat_t  qstat_i,
  input  wire hlfsd_bundle_t rdata_i,
  output logic               pop_o,
  hlfsd_out_if.source        out_o
);

  logic [EVT_SLOTS-1:0]       mask_q, mask_d;
  hlfsd_evt_t [EVT_SLOTS-1:0] evts_q;

  logic [2:0]           sel;
  logic [EVT_SLOTS-1:0] rest;
  logic                 fire, last, done;

  // lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = EVT_SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign rest = mask_q & ~(EVT_SLOTS'(1) << sel);
  assign last = (rest == '0);
  assign fire = out_o.valid & out_o.ready;
  assign done = ~out_o.valid | (fire & last);
  assign pop_o = done & ~qstat_i.empty;

  assign out_o.valid       = |mask_q;
  assign out_o.event_code  = evts_q[sel].code;
  assign out_o.event_value = evts_q[sel].value;
  assign out_o.last_of_run = last;

  always_comb begin
    mask_d = mask_q;
    if (pop_o) begin
      mask_d = rdata_i.mask;
    end else if (fire) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      evts_q <= rdata_i.evts;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  `HLFSD_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, fire && !last, out_o.valid)
  `HLFSD_ASSERT_NEXT(a_hold_stalled, clk_i, rst_ni, out_o.valid && !out_o.ready, $stable(mask_q))
  `HLFSD_ASSERT_NOW(a_single_is_last, clk_i, rst_ni, $onehot(mask_q), out_o.last_of_run)

endmodule

`default_nettype wire

### hw/rtl/hvac_link_frame_status_decoder_core.sv
// ----------------------------------------------------------------------------
// hvac_link_frame_status_decoder_core
// Decodes 20-byte link frames into sync, bad frame and status change events.
//
//   channel  dir  beat                                   ends when
//   in_i     in   kind, rx_byte, frame_start             valid && ready
//   out_o    out  event_code, event_value, last_of_run   valid && ready
//   cfg      in   cfg_idx_i, cfg_wdata_i                 cfg_we_i
//
// An input beat is taken every cycle while the bundle queue has room; the
// front resolves the whole item, including the frame checks, in that cycle.
// The back drains one event per cycle while out_o is ready, up to eight
// events per frame; that drain sets the sustained rate. A stalled output
// fills the queue (QUEUE_DEPTH bundles) before input is held off.
// Reset is asynchronous; state is usable as soon as it is released.
// ----------------------------------------------------------------------------
`default_nettype none

module hvac_link_frame_status_decoder_core
  import hlfsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  hlfsd_in_if.sink              in_i,
  hlfsd_out_if.source           out_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  hlfsd_bundle_t push_data, pop_data;
  hlfsd_qstat_t  qstat;
  logic          push, pop;

  hlfsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .bundle_o    (push_data)
  );

  hlfsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .pop_i   (pop),
    .rdata_o (pop_data),
    .qstat_o (qstat)
  );

  hlfsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .rdata_i (pop_data),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
